FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/obd2_pkg.sv
package obd2_pkg;

    localparam int OUT_W      = 37;
    localparam int ST_W       = 3;
    localparam int MAG_W      = 23;
    localparam int FRAC_NUM_W = 30;
    localparam int CLS_W      = 4;

    localparam logic [7:0] SVC_MODE01      = 8'h41;
    localparam logic [7:0] SENSOR_UNUSED_B = 8'hFF;

    localparam logic [1:0] OPT_FIRST  = 2'd1;
    localparam logic [1:0] OPT_SECOND = 2'd2;

    localparam logic [ST_W-1:0] ST_OK            = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_MODE01    = 3'd1;
    localparam logic [ST_W-1:0] ST_UNSUPPORTED   = 3'd2;
    localparam logic [ST_W-1:0] ST_SENSOR_UNUSED = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_OPTION    = 3'd4;

    // Scaling classes, named after the divisor of the formula.
    localparam logic [CLS_W-1:0] CLS_NONE  = 4'd0;
    localparam logic [CLS_W-1:0] CLS_D1    = 4'd1;
    localparam logic [CLS_W-1:0] CLS_D4    = 4'd2;
    localparam logic [CLS_W-1:0] CLS_D128  = 4'd3;
    localparam logic [CLS_W-1:0] CLS_D256  = 4'd4;
    localparam logic [CLS_W-1:0] CLS_D64K  = 4'd5;
    localparam logic [CLS_W-1:0] CLS_D255  = 4'd6;
    localparam logic [CLS_W-1:0] CLS_D10   = 4'd7;
    localparam logic [CLS_W-1:0] CLS_D20   = 4'd8;
    localparam logic [CLS_W-1:0] CLS_D100  = 4'd9;
    localparam logic [CLS_W-1:0] CLS_D200  = 4'd10;
    localparam logic [CLS_W-1:0] CLS_D1000 = 4'd11;

    // Rounding offsets (d-1)/2 for the odd factor d of each divisor.
    localparam int HALF5   = 2;
    localparam int HALF25  = 12;
    localparam int HALF125 = 62;
    localparam int HALF255 = 127;

    // Exact reciprocals: floor(x / d) = (x * M) >> S for every x below 2^N.
    localparam int RCP5_N    = 18;
    localparam int RCP5_S    = 21;
    localparam int RCP5_MW   = 19;
    localparam logic [RCP5_MW-1:0] RCP5_M =
        RCP5_MW'(((64'd1 << RCP5_S) + 64'd4) / 64'd5);

    localparam int RCP25_N   = 21;
    localparam int RCP25_S   = 26;
    localparam int RCP25_MW  = 22;
    localparam logic [RCP25_MW-1:0] RCP25_M =
        RCP25_MW'(((64'd1 << RCP25_S) + 64'd24) / 64'd25);

    localparam int RCP125_N  = 30;
    localparam int RCP125_S  = 37;
    localparam int RCP125_MW = 31;
    localparam logic [RCP125_MW-1:0] RCP125_M =
        RCP125_MW'(((64'd1 << RCP125_S) + 64'd124) / 64'd125);

    localparam int RCP255_N  = 23;
    localparam int RCP255_S  = 31;
    localparam int RCP255_MW = 24;
    localparam logic [RCP255_MW-1:0] RCP255_M =
        RCP255_MW'(((64'd1 << RCP255_S) + 64'd254) / 64'd255);

    // Widest reciprocal quotient.
    localparam int QUOT_W = RCP125_N + RCP125_MW - RCP125_S;

    // Decoded request handed from the decoder to the scaling stage.
    typedef struct packed {
        logic [ST_W-1:0]       status;
        logic [CLS_W-1:0]      cls;
        logic                  neg;
        logic [MAG_W-1:0]      mag;
        logic [FRAC_NUM_W-1:0] frac_num;
    } obd2_term_t;

endpackage

FILE: rtl/obd2_ifs.sv
interface obd2_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] service_byte;
    logic [7:0] pid;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic [7:0] data_c;
    logic [7:0] data_d;
    logic [1:0] option_select;

    modport source (
        output valid, service_byte, pid, data_a, data_b, data_c, data_d, option_select,
        input  ready
    );
    modport sink (
        input  valid, service_byte, pid, data_a, data_b, data_c, data_d, option_select,
        output ready
    );
endinterface

interface obd2_res_if;
    logic               valid;
    logic               ready;
    logic signed [36:0] value_fixed;
    logic [2:0]         status;

    modport source (
        output valid, value_fixed, status,
        input  ready
    );
    modport sink (
        input  valid, value_fixed, status,
        output ready
    );
endinterface

FILE: rtl/obd2_decode.sv
module obd2_decode import obd2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic [7:0] service_byte,
    input  logic [7:0] pid,
    input  logic [7:0] data_a,
    input  logic [7:0] data_b,
    input  logic [7:0] data_c,
    input  logic [7:0] data_d,
    input  logic [1:0] option_select,
    output obd2_term_t term
);

    // Remainders of 2^(FRAC_BITS-k) modulo the odd factor of each divisor,
    // premultiplied by the formula's gain where the gain is a constant.
    localparam int R255X  = 100 * ((1 << FRAC_BITS) % 255);
    localparam int R10    = (1 << (FRAC_BITS - 1)) % 5;
    localparam int R20    = (1 << (FRAC_BITS - 2)) % 5;
    localparam int R100   = (1 << (FRAC_BITS - 2)) % 25;
    localparam int R200   = (1 << (FRAC_BITS - 3)) % 25;
    localparam int R1000X = 79 * ((1 << (FRAC_BITS - 3)) % 125);

    localparam int TEMP_OFFSET   = 40;
    localparam int TORQUE_OFFSET = 125;
    localparam int TRIM_OFFSET   = 12800;
    localparam int O2_OFFSET     = 32768;
    localparam int CAT_OFFSET    = 400;

    // Returns {sign, magnitude} of x - base.
    function automatic logic [MAG_W:0] offset_mag(input logic [MAG_W-1:0] x,
                                                  input logic [MAG_W-1:0] base);
        if (x < base) begin
            return {1'b1, base - x};
        end
        return {1'b0, x - base};
    endfunction

    logic [15:0]      ab;
    logic [15:0]      cd;
    logic [MAG_W-1:0] a100;
    logic [MAG_W-1:0] b100;
    logic [MAG_W:0]   a_m40;
    logic [MAG_W:0]   a_m125;
    logic [MAG_W:0]   a_trim;
    logic [MAG_W:0]   b_trim;
    logic [MAG_W:0]   cd_o2;
    logic [MAG_W:0]   ab_cat;

    assign ab     = {data_a, data_b};
    assign cd     = {data_c, data_d};
    assign a100   = MAG_W'(data_a) * MAG_W'(100);
    assign b100   = MAG_W'(data_b) * MAG_W'(100);
    assign a_m40  = offset_mag(MAG_W'(data_a), MAG_W'(TEMP_OFFSET));
    assign a_m125 = offset_mag(MAG_W'(data_a), MAG_W'(TORQUE_OFFSET));
    assign a_trim = offset_mag(a100, MAG_W'(TRIM_OFFSET));
    assign b_trim = offset_mag(b100, MAG_W'(TRIM_OFFSET));
    assign cd_o2  = offset_mag(MAG_W'(cd), MAG_W'(O2_OFFSET));
    assign ab_cat = offset_mag(MAG_W'(ab), MAG_W'(CAT_OFFSET));

    always_comb
    begin
        term = '{status: ST_OK, cls: CLS_NONE, neg: 1'b0, mag: '0, frac_num: '0};
        if (service_byte != SVC_MODE01)
        begin
            term.status = ST_NOT_MODE01;
        end
        else if (pid inside {8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, 8'h52, 8'h5A, 8'h5B})
        begin
            term.cls      = CLS_D255;
            term.mag      = a100;
            term.frac_num = FRAC_NUM_W'(data_a) * FRAC_NUM_W'(R255X) + FRAC_NUM_W'(HALF255);
        end
        else if (pid inside {8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E, 8'h63})
        begin
            term.cls = CLS_D1;
            term.mag = MAG_W'(ab);
        end
        else if (pid inside {8'h05, 8'h0F, 8'h46, 8'h5C})
        begin
            term.cls              = CLS_D1;
            {term.neg, term.mag}  = a_m40;
        end
        else if (pid inside {8'h0B, 8'h0D, 8'h30, 8'h33})
        begin
            term.cls = CLS_D1;
            term.mag = MAG_W'(data_a);
        end
        else if (pid inside {[8'h06:8'h09], 8'h2D})
        begin
            term.cls             = CLS_D128;
            {term.neg, term.mag} = a_trim;
        end
        else if (pid == 8'h0A)
        begin
            term.cls = CLS_D1;
            term.mag = MAG_W'(data_a) * MAG_W'(3);
        end
        else if (pid == 8'h0C)
        begin
            term.cls = CLS_D4;
            term.mag = MAG_W'(ab);
        end
        else if (pid == 8'h5E)
        begin
            term.cls      = CLS_D20;
            term.mag      = MAG_W'(ab);
            term.frac_num = FRAC_NUM_W'(ab) * FRAC_NUM_W'(R20) + FRAC_NUM_W'(HALF5);
        end
        else if (pid inside {[8'h14:8'h1B]})
        begin
            case (option_select)
                OPT_FIRST:
                begin
                    term.cls      = CLS_D200;
                    term.mag      = MAG_W'(data_a);
                    term.frac_num = FRAC_NUM_W'(data_a) * FRAC_NUM_W'(R200)
                                    + FRAC_NUM_W'(HALF25);
                end
                OPT_SECOND:
                begin
                    if (data_b == SENSOR_UNUSED_B)
                    begin
                        term.status = ST_SENSOR_UNUSED;
                    end
                    else
                    begin
                        term.cls             = CLS_D128;
                        {term.neg, term.mag} = b_trim;
                    end
                end
                default:
                begin
                    term.status = ST_BAD_OPTION;
                end
            endcase
        end
        else if (pid inside {[8'h24:8'h2B]})
        begin
            case (option_select)
                OPT_FIRST:
                begin
                    term.cls = CLS_D64K;
                    term.mag = MAG_W'({ab, 1'b0});
                end
                OPT_SECOND:
                begin
                    term.cls = CLS_D64K;
                    term.mag = MAG_W'({cd, 3'b000});
                end
                default:
                begin
                    term.status = ST_BAD_OPTION;
                end
            endcase
        end
        else if (pid inside {[8'h34:8'h3B]})
        begin
            case (option_select)
                OPT_FIRST:
                begin
                    term.cls = CLS_D64K;
                    term.mag = MAG_W'({ab, 1'b0});
                end
                OPT_SECOND:
                begin
                    term.cls             = CLS_D256;
                    {term.neg, term.mag} = cd_o2;
                end
                default:
                begin
                    term.status = ST_BAD_OPTION;
                end
            endcase
        end
        else if (pid inside {[8'h3C:8'h3F]})
        begin
            term.cls             = CLS_D10;
            {term.neg, term.mag} = ab_cat;
            term.frac_num        = FRAC_NUM_W'(ab_cat[MAG_W-1:0]) * FRAC_NUM_W'(R10)
                                   + FRAC_NUM_W'(HALF5);
        end
        else if (pid == 8'h10)
        begin
            term.cls      = CLS_D100;
            term.mag      = MAG_W'(ab);
            term.frac_num = FRAC_NUM_W'(ab) * FRAC_NUM_W'(R100) + FRAC_NUM_W'(HALF25);
        end
        else if (pid inside {8'h61, 8'h62})
        begin
            term.cls             = CLS_D1;
            {term.neg, term.mag} = a_m125;
        end
        else if (pid == 8'h22)
        begin
            term.cls      = CLS_D1000;
            term.mag      = MAG_W'(ab) * MAG_W'(79);
            term.frac_num = FRAC_NUM_W'(ab) * FRAC_NUM_W'(R1000X) + FRAC_NUM_W'(HALF125);
        end
        else if (pid == 8'h23)
        begin
            term.cls = CLS_D1;
            term.mag = MAG_W'(ab) * MAG_W'(10);
        end
        else if (pid == 8'h44)
        begin
            term.cls = CLS_D64K;
            term.mag = MAG_W'({ab, 1'b0});
        end
        else
        begin
            term.status = ST_UNSUPPORTED;
        end
    end

endmodule

FILE: rtl/obd2_scale.sv
module obd2_scale import obd2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  obd2_term_t                term,
    output logic signed [OUT_W-1:0]   value_fixed,
    output logic [ST_W-1:0]           status
);

    // Integer parts floor(2^(FRAC_BITS-k) / d) of the odd-divisor classes.
    localparam int KW     = FRAC_BITS - 2;
    localparam int MAIN_W = MAG_W + KW;
    localparam int QW     = (FRAC_BITS + 24 > OUT_W + 1) ? FRAC_BITS + 24 : OUT_W + 1;
    localparam int K255   = (1 << FRAC_BITS) / 255;
    localparam int K10    = (1 << (FRAC_BITS - 1)) / 5;
    localparam int K20    = (1 << (FRAC_BITS - 2)) / 5;
    localparam int K100   = (1 << (FRAC_BITS - 2)) / 25;
    localparam int K200   = (1 << (FRAC_BITS - 3)) / 25;
    localparam int K1000  = (1 << (FRAC_BITS - 3)) / 125;

    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (OUT_W - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

    logic [RCP5_N+RCP5_MW-1:0]     p5;
    logic [RCP25_N+RCP25_MW-1:0]   p25;
    logic [RCP125_N+RCP125_MW-1:0] p125;
    logic [RCP255_N+RCP255_MW-1:0] p255;
    logic [KW-1:0]                 k_sel;
    logic [QUOT_W-1:0]             quot_sel;
    logic [MAIN_W-1:0]             main_term;
    logic [QW-1:0]                 scaled;
    logic [QW-1:0]                 q_mag;
    logic [QW-1:0]                 q_sat;

    assign p5   = term.frac_num[RCP5_N-1:0] * RCP5_M;
    assign p25  = term.frac_num[RCP25_N-1:0] * RCP25_M;
    assign p125 = term.frac_num[RCP125_N-1:0] * RCP125_M;
    assign p255 = term.frac_num[RCP255_N-1:0] * RCP255_M;

    always_comb
    begin
        case (term.cls)
            CLS_D10:
            begin
                k_sel    = KW'(K10);
                quot_sel = QUOT_W'(p5[RCP5_N+RCP5_MW-1:RCP5_S]);
            end
            CLS_D20:
            begin
                k_sel    = KW'(K20);
                quot_sel = QUOT_W'(p5[RCP5_N+RCP5_MW-1:RCP5_S]);
            end
            CLS_D100:
            begin
                k_sel    = KW'(K100);
                quot_sel = QUOT_W'(p25[RCP25_N+RCP25_MW-1:RCP25_S]);
            end
            CLS_D200:
            begin
                k_sel    = KW'(K200);
                quot_sel = QUOT_W'(p25[RCP25_N+RCP25_MW-1:RCP25_S]);
            end
            CLS_D1000:
            begin
                k_sel    = KW'(K1000);
                quot_sel = QUOT_W'(p125[RCP125_N+RCP125_MW-1:RCP125_S]);
            end
            CLS_D255:
            begin
                k_sel    = KW'(K255);
                quot_sel = QUOT_W'(p255[RCP255_N+RCP255_MW-1:RCP255_S]);
            end
            default:
            begin
                k_sel    = '0;
                quot_sel = '0;
            end
        endcase
    end

    assign main_term = MAIN_W'(term.mag) * MAIN_W'(k_sel);
    assign scaled    = QW'(term.mag) << FRAC_BITS;

    // Power-of-two divisors round by adding half an output step before the shift.
    always_comb
    begin
        case (term.cls)
            CLS_D1:    q_mag = scaled;
            CLS_D4:    q_mag = (scaled + QW'(2)) >> 2;
            CLS_D128:  q_mag = (scaled + QW'(64)) >> 7;
            CLS_D256:  q_mag = (scaled + QW'(128)) >> 8;
            CLS_D64K:  q_mag = (scaled + QW'(32768)) >> 16;
            CLS_D10, CLS_D20, CLS_D100, CLS_D200, CLS_D1000, CLS_D255:
                       q_mag = QW'(main_term) + QW'(quot_sel);
            default:   q_mag = '0;
        endcase
    end

    always_comb
    begin
        if (term.neg)
        begin
            q_sat = (q_mag > LIM_NEG) ? LIM_NEG : q_mag;
        end
        else
        begin
            q_sat = (q_mag > LIM_POS) ? LIM_POS : q_mag;
        end

        if (term.status != ST_OK)
        begin
            value_fixed = '0;
        end
        else if (term.neg)
        begin
            value_fixed = -$signed(q_sat[OUT_W-1:0]);
        end
        else
        begin
            value_fixed = $signed(q_sat[OUT_W-1:0]);
        end
    end

    assign status = term.status;

endmodule

FILE: rtl/obd2_pid_value_decoder.sv
// A request accepted into stage one moves into stage two, the output register, once stage
// two can take it. Throughput: one request per cycle without backpressure; each stage
// refills at the edge at which it empties.
// Under backpressure the two stages hold up to two requests before the input stalls.
// Reset (rst_n low, asynchronous) empties both stages; data registers are not reset.
`include "assert_macros.svh"

module obd2_pid_value_decoder import obd2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    obd2_req_if.sink   req,
    obd2_res_if.source res
);

    // Stage one holds the decoded request: status, scaling class, sign,
    // magnitude of the numerator and the remainder term for odd divisors.
    // Stage two holds the finished fixed-point value and is the output register.

    obd2_term_t              term_next;
    obd2_term_t              s1_term_reg;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_ready;
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    logic                    s2_ready;
    logic signed [OUT_W-1:0] value_next;
    logic signed [OUT_W-1:0] value_reg;
    logic [ST_W-1:0]         status_next;
    logic [ST_W-1:0]         status_reg;

    // The decoder picks the formula from the PID, checks the service byte and
    // the sub-value selector, and forms the numerator with constant gains only.
    obd2_decode #(
        .FRAC_BITS (FRAC_BITS)
    ) u_decode (
        .service_byte  (req.service_byte),
        .pid           (req.pid),
        .data_a        (req.data_a),
        .data_b        (req.data_b),
        .data_c        (req.data_c),
        .data_d        (req.data_d),
        .option_select (req.option_select),
        .term          (term_next)
    );

    // The scaling stage divides by the formula's constant with shifts or exact
    // reciprocals, rounds to nearest with ties away from zero and saturates.
    obd2_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .term        (s1_term_reg),
        .value_fixed (value_next),
        .status      (status_next)
    );

    // A stage can take a new request when it is empty or its content moves on
    // in the same cycle, so stage one still takes a request while a result
    // waits, as long as stage one itself is empty.
    assign s2_ready  = !s2_valid_reg || res.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? req.valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && s1_ready)
        begin
            s1_term_reg <= term_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign res.valid       = s2_valid_reg;
    assign res.value_fixed = value_reg;
    assign res.status      = status_reg;

    `ASSERT_IMPLIES(a_err_value_zero, res.valid && (res.status != ST_OK), res.value_fixed == '0, "error result carries a nonzero value")
    `ASSERT_IMPLIES(a_status_range, res.valid, res.status <= ST_BAD_OPTION, "result status code out of range")
    `ASSERT_NEXT(a_req_held, req.valid && req.ready, s1_valid_reg, "accepted request missing from stage one")
    `ASSERT_NEXT(a_mode_flagged, req.valid && req.ready && (req.service_byte != SVC_MODE01), s1_term_reg.status == ST_NOT_MODE01, "foreign service byte not flagged")
    `ASSERT_NEXT(a_status_moves, s1_valid_reg && s2_ready, res.valid && (res.status == $past(s1_term_reg.status)), "status changed between stages")

endmodule

FILE: dv/obd2_pid_value_decoder_test.sv
module obd2_pid_value_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import obd2_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 2;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int FLUSH_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    // Selector values that are neither the first nor the second sub-value.
    localparam logic [1:0] OPT_NONE  = 2'd0;
    localparam logic [1:0] OPT_SPARE = 2'd3;

    // Parameter identifiers, grouped by the formula that decodes them.
    localparam logic [7:0] PID_SUPPORT_MAP     = 8'h00;
    localparam logic [7:0] PID_MONITOR_STATUS  = 8'h01;
    localparam logic [7:0] PID_TOP             = 8'hFF;
    localparam logic [7:0] PID_ENGINE_LOAD     = 8'h04;
    localparam logic [7:0] PID_THROTTLE_POS    = 8'h11;
    localparam logic [7:0] PID_COMMANDED_EGR   = 8'h2C;
    localparam logic [7:0] PID_EVAP_PURGE      = 8'h2E;
    localparam logic [7:0] PID_FUEL_LEVEL      = 8'h2F;
    localparam logic [7:0] PID_REL_THROTTLE    = 8'h45;
    localparam logic [7:0] PID_ETHANOL         = 8'h52;
    localparam logic [7:0] PID_REL_PEDAL       = 8'h5A;
    localparam logic [7:0] PID_HYBRID_LIFE     = 8'h5B;
    localparam logic [7:0] PID_RUN_TIME        = 8'h1F;
    localparam logic [7:0] PID_DIST_MIL        = 8'h21;
    localparam logic [7:0] PID_DIST_CLEAR      = 8'h31;
    localparam logic [7:0] PID_TIME_MIL        = 8'h4D;
    localparam logic [7:0] PID_TIME_CLEAR      = 8'h4E;
    localparam logic [7:0] PID_REF_TORQUE      = 8'h63;
    localparam logic [7:0] PID_COOLANT_TEMP    = 8'h05;
    localparam logic [7:0] PID_INTAKE_TEMP     = 8'h0F;
    localparam logic [7:0] PID_AMBIENT_TEMP    = 8'h46;
    localparam logic [7:0] PID_OIL_TEMP        = 8'h5C;
    localparam logic [7:0] PID_INTAKE_MAP      = 8'h0B;
    localparam logic [7:0] PID_SPEED           = 8'h0D;
    localparam logic [7:0] PID_WARMUPS         = 8'h30;
    localparam logic [7:0] PID_BARO            = 8'h33;
    localparam logic [7:0] PID_FUEL_TRIM_LO    = 8'h06;
    localparam logic [7:0] PID_FUEL_TRIM_HI    = 8'h09;
    localparam logic [7:0] PID_EGR_ERROR       = 8'h2D;
    localparam logic [7:0] PID_FUEL_PRESSURE   = 8'h0A;
    localparam logic [7:0] PID_RPM             = 8'h0C;
    localparam logic [7:0] PID_FUEL_RATE       = 8'h5E;
    localparam logic [7:0] PID_O2_NARROW_LO    = 8'h14;
    localparam logic [7:0] PID_O2_NARROW_HI    = 8'h1B;
    localparam logic [7:0] PID_O2_VOLTS_LO     = 8'h24;
    localparam logic [7:0] PID_O2_VOLTS_HI     = 8'h2B;
    localparam logic [7:0] PID_O2_AMPS_LO      = 8'h34;
    localparam logic [7:0] PID_O2_AMPS_HI      = 8'h3B;
    localparam logic [7:0] PID_CAT_TEMP_LO     = 8'h3C;
    localparam logic [7:0] PID_CAT_TEMP_HI     = 8'h3F;
    localparam logic [7:0] PID_MAF             = 8'h10;
    localparam logic [7:0] PID_DEMAND_TORQUE   = 8'h61;
    localparam logic [7:0] PID_ACTUAL_TORQUE   = 8'h62;
    localparam logic [7:0] PID_RAIL_VACUUM     = 8'h22;
    localparam logic [7:0] PID_RAIL_GAUGE      = 8'h23;
    localparam logic [7:0] PID_EQUIV_RATIO     = 8'h44;

    typedef struct packed {
        logic [7:0] service_byte;
        logic [7:0] pid;
        logic [7:0] data_a;
        logic [7:0] data_b;
        logic [7:0] data_c;
        logic [7:0] data_d;
        logic [1:0] option_select;
    } pid_request_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value_fixed;
        logic [ST_W-1:0]         status;
    } pid_value_t;

    // Holds the decoded values that the block still owes, in request order,
    // and compares each returned value against the oldest of them.
    class decoded_value_tracker;
        pid_value_t awaited[$];
        int         failures;
        int         requests_seen;
        int         results_seen;
        int         status_tally[8];

        function new();
            failures      = 0;
            requests_seen = 0;
            results_seen  = 0;
            foreach (status_tally[i])
                status_tally[i] = 0;
        endfunction

        // Physical value of one reply, scaled by 2^FRAC_BITS and rounded to
        // nearest with ties away from zero, saturated to the output width.
        function pid_value_t decode_pid(pid_request_t rq);
            longint            a;
            longint            b;
            longint            c;
            longint            d;
            longint            ab;
            longint            cd;
            longint            num;
            longint unsigned   den;
            longint unsigned   mag;
            longint unsigned   q;
            longint unsigned   lim_pos;
            longint unsigned   lim_neg;
            longint            scaled;
            logic [7:0]        p;
            pid_value_t        r;

            a       = rq.data_a;
            b       = rq.data_b;
            c       = rq.data_c;
            d       = rq.data_d;
            ab      = 256 * a + b;
            cd      = 256 * c + d;
            p       = rq.pid;
            num     = 0;
            den     = 1;
            lim_pos = (64'd1 << (OUT_W - 1)) - 64'd1;
            lim_neg = 64'd1 << (OUT_W - 1);
            r.status      = ST_OK;
            r.value_fixed = '0;

            if (rq.service_byte != SVC_MODE01) begin
                r.status = ST_NOT_MODE01;
            end
            else if (p == PID_ENGINE_LOAD || p == PID_THROTTLE_POS || p == PID_COMMANDED_EGR ||
                     p == PID_EVAP_PURGE || p == PID_FUEL_LEVEL || p == PID_REL_THROTTLE ||
                     p == PID_ETHANOL || p == PID_REL_PEDAL || p == PID_HYBRID_LIFE) begin
                num = 100 * a;
                den = 255;
            end
            else if (p == PID_RUN_TIME || p == PID_DIST_MIL || p == PID_DIST_CLEAR ||
                     p == PID_TIME_MIL || p == PID_TIME_CLEAR || p == PID_REF_TORQUE) begin
                num = ab;
            end
            else if (p == PID_COOLANT_TEMP || p == PID_INTAKE_TEMP ||
                     p == PID_AMBIENT_TEMP || p == PID_OIL_TEMP) begin
                num = a - 40;
            end
            else if (p == PID_INTAKE_MAP || p == PID_SPEED || p == PID_WARMUPS ||
                     p == PID_BARO) begin
                num = a;
            end
            else if ((p >= PID_FUEL_TRIM_LO && p <= PID_FUEL_TRIM_HI) ||
                     p == PID_EGR_ERROR) begin
                num = 100 * a - 12800;
                den = 128;
            end
            else if (p == PID_FUEL_PRESSURE) begin
                num = 3 * a;
            end
            else if (p == PID_RPM) begin
                num = ab;
                den = 4;
            end
            else if (p == PID_FUEL_RATE) begin
                num = ab;
                den = 20;
            end
            else if (p >= PID_O2_NARROW_LO && p <= PID_O2_NARROW_HI) begin
                if (rq.option_select == OPT_FIRST) begin
                    num = a;
                    den = 200;
                end
                else if (rq.option_select == OPT_SECOND) begin
                    if (rq.data_b == SENSOR_UNUSED_B) begin
                        r.status = ST_SENSOR_UNUSED;
                    end
                    else begin
                        num = 100 * b - 12800;
                        den = 128;
                    end
                end
                else begin
                    r.status = ST_BAD_OPTION;
                end
            end
            else if (p >= PID_O2_VOLTS_LO && p <= PID_O2_VOLTS_HI) begin
                if (rq.option_select == OPT_FIRST) begin
                    num = 2 * ab;
                    den = 65536;
                end
                else if (rq.option_select == OPT_SECOND) begin
                    num = 8 * cd;
                    den = 65536;
                end
                else begin
                    r.status = ST_BAD_OPTION;
                end
            end
            else if (p >= PID_O2_AMPS_LO && p <= PID_O2_AMPS_HI) begin
                if (rq.option_select == OPT_FIRST) begin
                    num = 2 * ab;
                    den = 65536;
                end
                else if (rq.option_select == OPT_SECOND) begin
                    num = cd - 32768;
                    den = 256;
                end
                else begin
                    r.status = ST_BAD_OPTION;
                end
            end
            else if (p >= PID_CAT_TEMP_LO && p <= PID_CAT_TEMP_HI) begin
                num = ab - 400;
                den = 10;
            end
            else if (p == PID_MAF) begin
                num = ab;
                den = 100;
            end
            else if (p == PID_DEMAND_TORQUE || p == PID_ACTUAL_TORQUE) begin
                num = a - 125;
            end
            else if (p == PID_RAIL_VACUUM) begin
                num = 79 * ab;
                den = 1000;
            end
            else if (p == PID_RAIL_GAUGE) begin
                num = 10 * ab;
            end
            else if (p == PID_EQUIV_RATIO) begin
                num = 2 * ab;
                den = 65536;
            end
            else begin
                r.status = ST_UNSUPPORTED;
            end

            if (r.status == ST_OK) begin
                mag = (num < 0) ? longint'(-num) : num;
                q   = ((mag << FRAC_BITS) + den / 2) / den;
                if (num < 0) begin
                    if (q > lim_neg)
                        q = lim_neg;
                    scaled = -longint'(q);
                end
                else begin
                    if (q > lim_pos)
                        q = lim_pos;
                    scaled = longint'(q);
                end
                r.value_fixed = scaled[OUT_W-1:0];
            end
            return r;
        endfunction

        function void note_request(pid_request_t rq);
            awaited = {awaited, decode_pid(rq)};
            requests_seen++;
        endfunction

        function void check_result(logic signed [OUT_W-1:0] value_fixed,
                                   logic [ST_W-1:0] status);
            pid_value_t want;

            results_seen++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Result %0d arrived with no request pending: value %0d status %0d",
                             results_seen, value_fixed, status);
            end
            else begin
                want = awaited.pop_front();
                status_tally[want.status]++;
                if (value_fixed !== want.value_fixed || status !== want.status) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("Result %0d mismatch: expected value %0d status %0d, got %0d %0d",
                                 results_seen, want.value_fixed, want.status,
                                 value_fixed, status);
                end
            end
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                $display("%0d decoded values never came back", awaited.size());
                failures += awaited.size();
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    obd2_req_if req_ch();
    obd2_res_if res_ch();

    obd2_pid_value_decoder #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .res  (res_ch.source)
    );

    decoded_value_tracker tracker;

    // Idle rates in percent per cycle for the request side and the result side.
    int send_idle_pct;
    int recv_stall_pct;

    // Mirrors the value last scheduled on req_ch.valid, so that valid never gets
    // two nonblocking updates within one time step.
    bit req_raised;

    int         cycle_count;
    logic [7:0] known_pids[$];

    always #(CLK_HALF) clk = ~clk;

    // The result side stalls at random, at the rate of the current phase.
    always @(posedge clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Both handshakes are observed at the same edge at which they complete, from
    // values that were settled before that edge. A request is recorded before
    // any result of the same edge is checked; with stage one and the output register
    // between them, the two never concern the same request.
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready)
                tracker.note_request('{req_ch.service_byte, req_ch.pid, req_ch.data_a,
                                       req_ch.data_b, req_ch.data_c, req_ch.data_d,
                                       req_ch.option_select});
            if (res_ch.valid && res_ch.ready)
                tracker.check_result(res_ch.value_fixed, res_ch.status);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.awaited.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic pid_request_t make_request(logic [7:0] service_byte, logic [7:0] pid,
                                                  logic [7:0] data_a, logic [7:0] data_b,
                                                  logic [7:0] data_c, logic [7:0] data_d,
                                                  logic [1:0] option_select);
        pid_request_t rq;

        rq.service_byte  = service_byte;
        rq.pid           = pid;
        rq.data_a        = data_a;
        rq.data_b        = data_b;
        rq.data_c        = data_c;
        rq.data_d        = data_d;
        rq.option_select = option_select;
        return rq;
    endfunction

    // Appends one request to the end of a list of requests.
    function automatic void queue_up(ref pid_request_t list[$], input pid_request_t rq);
        list = {list, rq};
    endfunction

    // Data bytes lean on their extremes now and then, since most formulas are
    // most likely to go wrong at zero and at full scale.
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;

        case ($urandom_range(0, 15))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    // Most random requests are well-formed mode 01 replies for a PID with a
    // formula and a valid selector; the rest are foreign services, unknown
    // PIDs and bad selectors. Byte B is pushed to FF often enough to hit the
    // unused trim sensor case on the oxygen sensor PIDs.
    function automatic pid_request_t random_request();
        pid_request_t rq;
        int           sel;

        rq.service_byte = ($urandom_range(0, 19) == 0) ? 8'($urandom) : SVC_MODE01;
        if ($urandom_range(0, 9) < 8)
            rq.pid = known_pids[$urandom_range(0, known_pids.size() - 1)];
        else
            rq.pid = 8'($urandom);
        rq.data_a = pick_byte();
        rq.data_b = ($urandom_range(0, 7) == 0) ? SENSOR_UNUSED_B : pick_byte();
        rq.data_c = pick_byte();
        rq.data_d = pick_byte();
        sel = $urandom_range(0, 9);
        if (sel < 4)
            rq.option_select = OPT_FIRST;
        else if (sel < 8)
            rq.option_select = OPT_SECOND;
        else if (sel == 8)
            rq.option_select = OPT_NONE;
        else
            rq.option_select = OPT_SPARE;
        return rq;
    endfunction

    // Presents one request after a random idle stretch and returns at the edge
    // at which the block takes it. Valid stays high when the next request
    // follows with no gap.
    task automatic send_request(pid_request_t rq);
        int gap;

        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            if (req_raised)
                req_ch.valid <= 1'b0;
            req_raised = 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_raised            = 1'b1;
        req_ch.service_byte  <= rq.service_byte;
        req_ch.pid           <= rq.pid;
        req_ch.data_a        <= rq.data_a;
        req_ch.data_b        <= rq.data_b;
        req_ch.data_c        <= rq.data_c;
        req_ch.data_d        <= rq.data_d;
        req_ch.option_select <= rq.option_select;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stops sending and holds off until every decoded value has come back.
    task automatic drain_results();
        if (req_raised)
            req_ch.valid <= 1'b0;
        req_raised = 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        pid_request_t directed[$];
        pid_value_t   probe;
        int           phase;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        cycle_count          = 0;
        req_raised           = 1'b0;
        send_idle_pct        = 28;
        recv_stall_pct       = 85;
        req_ch.valid         = 1'b0;
        req_ch.service_byte  = '0;
        req_ch.pid           = '0;
        req_ch.data_a        = '0;
        req_ch.data_b        = '0;
        req_ch.data_c        = '0;
        req_ch.data_d        = '0;
        req_ch.option_select = '0;
        res_ch.ready         = 1'b0;
        tracker              = new();

        // Every PID that has a formula, found by asking the predictor itself.
        for (int p = 0; p < 256; p++) begin
            probe = tracker.decode_pid(make_request(SVC_MODE01, 8'(p), 8'h00, 8'h00,
                                                    8'h00, 8'h00, OPT_FIRST));
            if (probe.status != ST_UNSUPPORTED)
                known_pids = {known_pids, 8'(p)};
        end

        // Directed requests: foreign services, PIDs with no formula, each
        // formula at the end of its range that stresses it most, the trim
        // sensor that reports itself unused, both bad selector values, and a
        // selector that a plain PID must ignore.
        queue_up(directed, make_request(8'h00, PID_RPM, 8'h12, 8'h34, 8'h00, 8'h00, OPT_FIRST));
        queue_up(directed, make_request(8'hFF, PID_RPM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, OPT_SPARE));
        queue_up(directed, make_request(SVC_MODE01, PID_SUPPORT_MAP, 8'hBE, 8'h1F, 8'hA8,
                                        8'h13, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_MONITOR_STATUS, 8'h00, 8'h07, 8'hE5,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_TOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                        OPT_SECOND));
        queue_up(directed, make_request(SVC_MODE01, PID_ENGINE_LOAD, 8'hFF, 8'h00, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_FUEL_LEVEL, 8'h01, 8'h00, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_RUN_TIME, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                        OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_COOLANT_TEMP, 8'h00, 8'h00, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_SPEED, 8'hFF, 8'h00, 8'h00, 8'h00,
                                        OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_FUEL_TRIM_LO, 8'h00, 8'h00, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_EGR_ERROR, 8'hFF, 8'h00, 8'h00, 8'h00,
                                        OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_FUEL_PRESSURE, 8'hFF, 8'h00, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_RPM, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                        OPT_SPARE));
        queue_up(directed, make_request(SVC_MODE01, PID_FUEL_RATE, 8'h00, 8'h0B, 8'h00, 8'h00,
                                        OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_NARROW_LO, 8'hFF, 8'h80, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_NARROW_HI, 8'h5A, 8'hFE, 8'h00,
                                        8'h00, OPT_SECOND));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_NARROW_LO, 8'h5A, SENSOR_UNUSED_B,
                                        8'h00, 8'h00, OPT_SECOND));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_NARROW_LO, 8'h5A, 8'h80, 8'h00,
                                        8'h00, OPT_NONE));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_VOLTS_HI, 8'hFF, 8'hFF, 8'hFF,
                                        8'hFF, OPT_SECOND));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_VOLTS_LO, 8'h80, 8'h00, 8'h00,
                                        8'h00, OPT_SPARE));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_AMPS_LO, 8'hFF, 8'hFF, 8'h00,
                                        8'h00, OPT_SECOND));
        queue_up(directed, make_request(SVC_MODE01, PID_O2_AMPS_HI, 8'h00, 8'h01, 8'hFF,
                                        8'hFF, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_CAT_TEMP_LO, 8'h00, 8'h00, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_MAF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                        OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_DEMAND_TORQUE, 8'h00, 8'h00, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_RAIL_VACUUM, 8'hFF, 8'hFF, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_RAIL_GAUGE, 8'hFF, 8'hFF, 8'h00,
                                        8'h00, OPT_FIRST));
        queue_up(directed, make_request(SVC_MODE01, PID_EQUIV_RATIO, 8'h80, 8'h01, 8'h00,
                                        8'h00, OPT_FIRST));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);
        drain_results();

        // Three random phases: a sender that idles lightly against a receiver
        // that stalls heavily, then the reverse, then full rate on both sides.
        // The block is drained at the end of each phase.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 85;
                end
                1: begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 28;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_ITEMS / 3)
                send_request(random_request());
            drain_results();
        end

        repeat (FLUSH_CYCLES) @(posedge clk);
        tracker.close_out();

        $display("Decoded %0d requests (%0d directed), %0d results in %0d cycles.",
                 tracker.requests_seen, directed.size(), tracker.results_seen, cycle_count);
        $display("Status mix: ok %0d, other service %0d, no formula %0d, unused %0d, bad %0d.",
                 tracker.status_tally[ST_OK], tracker.status_tally[ST_NOT_MODE01],
                 tracker.status_tally[ST_UNSUPPORTED], tracker.status_tally[ST_SENSOR_UNUSED],
                 tracker.status_tally[ST_BAD_OPTION]);
        if (tracker.failures == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("%0d failures", tracker.failures);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
